>>> rtl/core/mss_pkg.sv
`timescale 1ns / 1ps

package mss_pkg;

  // Field widths
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned SHADE_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);
  localparam logic [SHADE_W-1:0] SHADE_MAX   = {SHADE_W{1'b1}};

  // Image size, powers of two
  localparam int unsigned IMAGE_WIDTH  = 1024;
  localparam int unsigned IMAGE_HEIGHT = 1024;

  // Signed Q4.F fixed point for c, z and |z|^2
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned Q_W       = FRAC_BITS + 4;

  typedef logic signed [Q_W-1:0] qval_t;
  typedef logic signed [Q_W:0]   qwide_t;

  localparam qval_t Q_MAX  = qval_t'({1'b0, {(Q_W-1){1'b1}}});
  localparam qval_t Q_MIN  = qval_t'({1'b1, {(Q_W-1){1'b0}}});
  localparam qval_t Q_FOUR = qval_t'(Q_W'(4) << FRAC_BITS);

  // 2*pos/size == pos << (F + 1 - log2(size)) for power-of-two sizes
  localparam int unsigned X_SHIFT = FRAC_BITS + 1 - $clog2(IMAGE_WIDTH);
  localparam int unsigned Y_SHIFT = FRAC_BITS + 1 - $clog2(IMAGE_HEIGHT);
  localparam qwide_t CR_OFS = qwide_t'((Q_W+1)'(3) << (FRAC_BITS - 1));
  localparam qwide_t CI_OFS = qwide_t'((Q_W+1)'(1) << FRAC_BITS);

  // Log2 unit: unsigned input with 16 fraction bits, result Q16
  localparam int unsigned LOG_FB     = 16;
  localparam int unsigned LOG_IN_W   = 22;
  localparam int unsigned LOG_EXP_W  = 3;
  localparam int unsigned LOG_OUT_W  = LOG_EXP_W + LOG_FB;
  localparam int unsigned LOG_P_W    = $clog2(LOG_IN_W);
  localparam int unsigned TAB_IDX_W  = 4;
  localparam int unsigned TAB_REM_W  = LOG_FB - TAB_IDX_W;
  localparam int unsigned TAB_VAL_W  = LOG_FB + 1;
  localparam int unsigned TAB_DIFF_W = 13;
  localparam logic [LOG_IN_W-1:0] LOG_ONE = LOG_IN_W'(1) << LOG_FB;

  // Smooth count: mu = (n+1)<<16 - log2(log2|z|^2) + 1 - log2(ln 2)
  localparam int unsigned MU_W    = LIMIT_W + 1 + LOG_FB;
  localparam int unsigned MU_SHR  = 5;
  localparam int unsigned SHADE_SHR = 9;
  localparam logic [MU_W:0] MU_BIAS = (MU_W+1)'(65536 + 34653);

  // Clamp a one-bit-wider sum back into Q4.F
  function automatic qval_t sat_q(input qwide_t v);
    if (v[Q_W] != v[Q_W-1]) begin
      sat_q = v[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      sat_q = qval_t'(v[Q_W-1:0]);
    end
  endfunction

  function automatic qval_t sat_add(input qval_t a, input qval_t b);
    sat_add = sat_q(qwide_t'({a[Q_W-1], a}) + qwide_t'({b[Q_W-1], b}));
  endfunction

  function automatic logic [Q_W-1:0] q_mag(input qval_t v);
    q_mag = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  // Magnitude product -> truncate toward zero, saturate, apply sign
  function automatic qval_t prod_to_q(input logic [2*Q_W-1:0] mag, input logic neg);
    logic [2*Q_W-1:0] m;
    qval_t r;
    m = mag >> FRAC_BITS;
    r = qval_t'({1'b0, m[Q_W-2:0]});
    if (|m[2*Q_W-1:Q_W-1]) begin
      prod_to_q = neg ? Q_MIN : Q_MAX;
    end else begin
      prod_to_q = neg ? qval_t'(-r) : r;
    end
  endfunction

  function automatic qval_t coord_map(input logic [PIX_W-1:0] pos, input int unsigned shift,
                                      input qwide_t ofs);
    qwide_t v;
    v = qwide_t'((Q_W+1)'(pos) << shift);
    coord_map = sat_q(v - ofs);
  endfunction

  // log2(1 + k/16) in Q16
  function automatic logic [TAB_VAL_W-1:0] log_tab(input logic [TAB_IDX_W:0] idx);
    unique case (idx)
      5'd0:    log_tab = 17'd0;
      5'd1:    log_tab = 17'd5732;
      5'd2:    log_tab = 17'd11136;
      5'd3:    log_tab = 17'd16248;
      5'd4:    log_tab = 17'd21098;
      5'd5:    log_tab = 17'd25711;
      5'd6:    log_tab = 17'd30109;
      5'd7:    log_tab = 17'd34312;
      5'd8:    log_tab = 17'd38336;
      5'd9:    log_tab = 17'd42196;
      5'd10:   log_tab = 17'd45904;
      5'd11:   log_tab = 17'd49472;
      5'd12:   log_tab = 17'd52911;
      5'd13:   log_tab = 17'd56229;
      5'd14:   log_tab = 17'd59434;
      5'd15:   log_tab = 17'd62534;
      5'd16:   log_tab = 17'd65536;
      default: log_tab = 17'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/mss_if.sv
`timescale 1ns / 1ps

interface mss_pix_if;
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::PIX_W-1:0]     pixel_x;
  logic [mss_pkg::PIX_W-1:0]     pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mss_shade_if;
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::SHADE_W-1:0]   shade;
  logic [mss_pkg::LIMIT_W-1:0]   iterations_used;
  logic                          inside_set;

  modport source (output valid, output shade, output iterations_used, output inside_set,
                  input ready);
  modport sink   (input valid, input shade, input iterations_used, input inside_set,
                  output ready);
endinterface

>>> rtl/core/mss_log2.sv
`timescale 1ns / 1ps

// log2 in Q16 of an unsigned Q16 value >= 1.0: leading-one search,
// 17-entry table on the top mantissa bits, linear interpolation below.
module mss_log2 (
  input  logic [mss_pkg::LOG_IN_W-1:0]  val_i,
  output logic [mss_pkg::LOG_OUT_W-1:0] log_o
);

  logic [mss_pkg::LOG_P_W-1:0]      msb;
  logic                             found;
  logic [mss_pkg::LOG_IN_W-1:0]     norm;
  logic [mss_pkg::TAB_IDX_W-1:0]    idx;
  logic [mss_pkg::TAB_REM_W-1:0]    rem;
  logic [mss_pkg::TAB_VAL_W-1:0]    base;
  logic [mss_pkg::TAB_VAL_W-1:0]    nxt;
  logic [mss_pkg::TAB_DIFF_W-1:0]   diff;
  logic [mss_pkg::TAB_DIFF_W+mss_pkg::TAB_REM_W-1:0] ip;
  logic [mss_pkg::LOG_FB-1:0]       frac;

  always_comb begin
    msb   = '0;
    found = 1'b0;
    for (int i = 0; i < mss_pkg::LOG_IN_W; i++) begin
      if (val_i[i]) begin
        msb   = mss_pkg::LOG_P_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    norm = val_i >> (msb - mss_pkg::LOG_P_W'(mss_pkg::LOG_FB));
    idx  = norm[mss_pkg::LOG_FB-1 -: mss_pkg::TAB_IDX_W];
    rem  = norm[mss_pkg::TAB_REM_W-1:0];
    base = mss_pkg::log_tab({1'b0, idx});
    nxt  = mss_pkg::log_tab({1'b0, idx} + 5'd1);
    diff = mss_pkg::TAB_DIFF_W'(nxt - base);
    ip   = $bits(ip)'(diff) * $bits(ip)'(rem);
    frac = mss_pkg::LOG_FB'(base + mss_pkg::TAB_VAL_W'(ip >> mss_pkg::TAB_REM_W));
    if (found && (msb >= mss_pkg::LOG_P_W'(mss_pkg::LOG_FB))) begin
      log_o = {mss_pkg::LOG_EXP_W'(msb - mss_pkg::LOG_P_W'(mss_pkg::LOG_FB)), frac};
    end else begin
      log_o = '0;
    end
  end

endmodule

>>> rtl/core/mandelbrot_smooth_shade.sv
// Mandelbrot escape-time shader with smooth log-scaled shading. Each request
// on pix_i is one pixel; it maps to c = (2x/1024 - 1.5) + i(2y/1024 - 1) in
// signed Q4.28 and the block iterates z = z*z + c from z = c until |z|^2 >= 4
// or iteration_limit iterations have run (limit written through cfg_we_i /
// cfg_wdata_i, 128 after reset; the user must write it only while the block
// is idle, the block itself does not enforce this). One result request
// leaves on shade_o per pixel: the shade byte, the iteration count and
// inside_set, which is 1 (with shade 255) for points that never escape. All
// complex arithmetic goes through one 32x32 multiplier, three products (zr^2,
// zi^2, zr*zi) per iteration; an escaped point then runs the log shading
// states ST_LMAG, ST_LLG and ST_LMU. Every point ends in ST_EMIT and returns
// to ST_IDLE to take the next pixel. The block takes one pixel at a time;
// pix_i.ready is high only when it is idle, and a finished result waits in
// the output register while the next pixel is already being worked on.
`timescale 1ns / 1ps

module mandelbrot_smooth_shade (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mss_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  mss_pix_if.sink                       pix_i,
  mss_shade_if.source                   shade_o
);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a pixel
    ST_RR,     // issue zr*zr, retire zr*zi into zi
    ST_II,     // issue zi*zi, retire zr*zr
    ST_RI,     // issue zr*zi, retire zi*zi, escape / limit test
    ST_LMAG,   // log2 |z|^2
    ST_LLG,    // log2 log2 |z|^2 -> smooth count mu
    ST_LMU,    // log2 (mu/32 + 1) -> shade
    ST_EMIT    // move result to output register
  } state_e;

  state_e state_q;

  // Configuration
  logic [mss_pkg::LIMIT_W-1:0] limit_q;

  // Iteration datapath
  mss_pkg::qval_t cr_q, ci_q, zr_q, zi_q, rr_q, mag2_q;
  logic                          first_q;
  logic [mss_pkg::LIMIT_W-1:0]   n_q;

  // Shared multiplier: operand select, magnitude product register
  mss_pkg::qval_t                mul_a, mul_b;
  logic [2*mss_pkg::Q_W-1:0]     prod_mag_q;
  logic                          prod_neg_q;
  mss_pkg::qval_t                prod_val;

  mss_pkg::qval_t                zr_d, zi_d, mag2_d;
  logic                          escape, at_limit;

  // Log shading
  logic [mss_pkg::LOG_IN_W-1:0]  log_in;
  logic [mss_pkg::LOG_OUT_W-1:0] log_out;
  logic [mss_pkg::LOG_OUT_W-1:0] lg_q;
  logic [mss_pkg::MU_W-1:0]      mu_q, mu_d;
  logic [mss_pkg::MU_W:0]        mu_raw;
  logic [mss_pkg::LIMIT_W:0]     n_inc;
  logic [mss_pkg::LOG_OUT_W-mss_pkg::SHADE_SHR-1:0] shade_wide;
  logic [mss_pkg::SHADE_W-1:0]   shade_d;

  // Pending result and output register
  logic [mss_pkg::SHADE_W-1:0]   res_shade_q;
  logic                          res_inside_q;
  logic                          out_valid_q;
  logic [mss_pkg::SHADE_W-1:0]   out_shade_q;
  logic [mss_pkg::LIMIT_W-1:0]   out_iter_q;
  logic                          out_inside_q;
  logic                          out_free;

  assign pix_i.ready             = (state_q == ST_IDLE);
  assign shade_o.valid           = out_valid_q;
  assign shade_o.shade           = out_shade_q;
  assign shade_o.iterations_used = out_iter_q;
  assign shade_o.inside_set      = out_inside_q;

  assign out_free = !out_valid_q || shade_o.ready;

  // ---------------------------------------------------------------------
  // Multiplier operand select by phase
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (state_q)
      ST_II:   begin mul_a = zi_q; mul_b = zi_q; end
      ST_RI:   begin mul_a = zr_q; mul_b = zi_q; end
      default: begin mul_a = zr_q; mul_b = zr_q; end
    endcase
  end

  assign prod_val = mss_pkg::prod_to_q(prod_mag_q, prod_neg_q);

  // In ST_RI prod_val is zi^2, in ST_RR (after the first round) it is zr*zi
  assign mag2_d   = mss_pkg::sat_add(rr_q, prod_val);
  assign zr_d     = mss_pkg::sat_add(mss_pkg::sat_add(rr_q, mss_pkg::qval_t'(-prod_val)), cr_q);
  assign zi_d     = mss_pkg::sat_add(mss_pkg::sat_add(prod_val, prod_val), ci_q);
  assign escape   = (mag2_d >= mss_pkg::Q_FOUR);
  assign at_limit = (n_q >= limit_q);

  // ---------------------------------------------------------------------
  // Shared log2 unit, three uses per escaped pixel
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (state_q)
      ST_LLG:  log_in = mss_pkg::LOG_IN_W'(lg_q);
      ST_LMU:  log_in = mss_pkg::LOG_IN_W'(mu_q >> mss_pkg::MU_SHR) + mss_pkg::LOG_ONE;
      default: log_in = mss_pkg::LOG_IN_W'(unsigned'(mag2_q) >>
                                           (mss_pkg::FRAC_BITS - mss_pkg::LOG_FB));
    endcase
  end

  mss_log2 u_log2 (
    .val_i (log_in),
    .log_o (log_out)
  );

  // mu = (n+1) + 1 - log2(ln 2) - log2(log2 |z|^2), kept non-negative
  always_comb begin
    n_inc  = {1'b0, n_q} + (mss_pkg::LIMIT_W+1)'(1);
    mu_raw = (mss_pkg::MU_W+1)'({n_inc, {mss_pkg::LOG_FB{1'b0}}}) + mss_pkg::MU_BIAS
             - (mss_pkg::MU_W+1)'(log_out);
    mu_d   = mu_raw[mss_pkg::MU_W] ? '0 : mu_raw[mss_pkg::MU_W-1:0];
  end

  always_comb begin
    shade_wide = log_out[mss_pkg::LOG_OUT_W-1:mss_pkg::SHADE_SHR];
    if (shade_wide > $bits(shade_wide)'(mss_pkg::SHADE_MAX)) begin
      shade_d = mss_pkg::SHADE_MAX;
    end else begin
      shade_d = mss_pkg::SHADE_W'(shade_wide);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer, configuration and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      limit_q      <= mss_pkg::LIMIT_RESET;
      out_valid_q  <= 1'b0;
      out_shade_q  <= '0;
      out_iter_q   <= '0;
      out_inside_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (pix_i.valid) begin
            state_q <= ST_RR;
          end
        end
        ST_RR:   state_q <= ST_II;
        ST_II:   state_q <= ST_RI;
        ST_RI: begin
          if (escape) begin
            state_q <= ST_LMAG;
          end else if (at_limit) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_RR;
          end
        end
        ST_LMAG: state_q <= ST_LLG;
        ST_LLG:  state_q <= ST_LMU;
        ST_LMU:  state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q  <= 1'b1;
        out_shade_q  <= res_shade_q;
        out_iter_q   <= n_q;
        out_inside_q <= res_inside_q;
      end else if (shade_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_mag_q <= (2*mss_pkg::Q_W)'(mss_pkg::q_mag(mul_a)) *
                  (2*mss_pkg::Q_W)'(mss_pkg::q_mag(mul_b));
    prod_neg_q <= mul_a[mss_pkg::Q_W-1] ^ mul_b[mss_pkg::Q_W-1];

    unique case (state_q)
      ST_IDLE: begin
        cr_q    <= mss_pkg::coord_map(pix_i.pixel_x, mss_pkg::X_SHIFT, mss_pkg::CR_OFS);
        ci_q    <= mss_pkg::coord_map(pix_i.pixel_y, mss_pkg::Y_SHIFT, mss_pkg::CI_OFS);
        zr_q    <= mss_pkg::coord_map(pix_i.pixel_x, mss_pkg::X_SHIFT, mss_pkg::CR_OFS);
        zi_q    <= mss_pkg::coord_map(pix_i.pixel_y, mss_pkg::Y_SHIFT, mss_pkg::CI_OFS);
        n_q     <= '0;
        first_q <= 1'b1;
      end
      ST_RR: begin
        // zr*zi of the previous round lands here; zi*zi is issued next
        if (!first_q) begin
          zi_q <= zi_d;
        end
        first_q <= 1'b0;
      end
      ST_II: begin
        rr_q <= prod_val;
      end
      ST_RI: begin
        mag2_q <= mag2_d;
        if (!escape && at_limit) begin
          res_shade_q  <= mss_pkg::SHADE_MAX;
          res_inside_q <= 1'b1;
        end else if (!escape) begin
          n_q  <= n_q + mss_pkg::LIMIT_W'(1);
          zr_q <= zr_d;
        end
      end
      ST_LMAG: lg_q <= log_out;
      ST_LLG:  mu_q <= mu_d;
      ST_LMU: begin
        res_shade_q  <= shade_d;
        res_inside_q <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/mss_checker.sv
`timescale 1ns / 1ps

module mss_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mss_pkg::SHADE_W-1:0]   shade_i,
  input  logic [mss_pkg::LIMIT_W-1:0]   iter_i,
  input  logic                          inside_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // one pixel at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready while a pixel is in work");

  // at least one full test round before any result
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3))
    else $error("result too soon after a request");

  a_inside_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && inside_i) |-> (shade_i == mss_pkg::SHADE_MAX))
    else $error("inside point without full shade");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      out_valid_i && $stable(shade_i) && $stable(iter_i) && $stable(inside_i))
    else $error("stalled result changed");

endmodule

bind mandelbrot_smooth_shade mss_checker u_mss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (shade_o.valid),
  .out_ready_i (shade_o.ready),
  .shade_i     (shade_o.shade),
  .iter_i      (shade_o.iterations_used),
  .inside_i    (shade_o.inside_set)
);

>>> sim/mss_shade_checker.sv
`timescale 1ns / 1ps

module mss_shade_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mss_pkg::LIMIT_W-1:0] cfg_wdata_i,
  mss_pix_if                          pix,
  mss_shade_if                        res,
  output int unsigned                 errors_o,
  output int unsigned                 outstanding_o
);

  // Q4.F limits and the escape radius squared
  localparam longint Q_HI     = (longint'(1) << (mss_pkg::FRAC_BITS + 3)) - 1;
  localparam longint Q_LO     = -Q_HI - 1;
  localparam longint Q_ESCAPE = longint'(4) << mss_pkg::FRAC_BITS;
  // log2(ln 2) - 1 in Q16
  localparam longint LOG2_LN2_M1 = -34653 - 65536;
  localparam int LOG2_STEPS [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
  };

  typedef struct packed {
    logic [mss_pkg::PIX_W-1:0]   px;
    logic [mss_pkg::PIX_W-1:0]   py;
    logic [mss_pkg::SHADE_W-1:0] shade;
    logic [mss_pkg::LIMIT_W-1:0] iters;
    logic                        in_set;
  } shade_rec_t;

  shade_rec_t                  shades_due[$];
  shade_rec_t                  want;
  logic [mss_pkg::LIMIT_W-1:0] limit_q;

  function automatic longint q_clamp(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Product truncated toward zero, then saturated
  function automatic longint q_mul(input longint a, input longint b);
    longint ma, mb, mag;
    logic   neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = (ma * mb) >>> mss_pkg::FRAC_BITS;
    if (mag > Q_HI) return neg ? Q_LO : Q_HI;
    return neg ? -mag : mag;
  endfunction

  // log2 of v > 0 with fb fraction bits, Q16 result, table plus linear step
  function automatic longint log2_q16(input longint v, input int fb);
    int     msb;
    longint m;
    int     f, idx, low;
    if (v <= 0) return 0;
    msb = 62;
    while (!v[msb]) msb--;
    m   = (msb >= 16) ? (v >>> (msb - 16)) : (v << (16 - msb));
    f   = int'(m - 65536) & 'hFFFF;
    idx = f >> 12;
    low = f & 'hFFF;
    return longint'(msb - fb) * 65536 + LOG2_STEPS[idx]
         + ((longint'(LOG2_STEPS[idx + 1] - LOG2_STEPS[idx]) * low) >>> 12);
  endfunction

  function automatic shade_rec_t predict_shade(input logic [mss_pkg::PIX_W-1:0]   px,
                                               input logic [mss_pkg::PIX_W-1:0]   py,
                                               input logic [mss_pkg::LIMIT_W-1:0] lim);
    longint      cr, ci, zr, zi, rr, ii, ri, mag2, lg, ll, mu, lv;
    int unsigned n;
    shade_rec_t  r;
    r.px = px;
    r.py = py;
    cr = q_clamp(((longint'(px) * 2) << mss_pkg::FRAC_BITS) / longint'(mss_pkg::IMAGE_WIDTH)
                 - (longint'(3) << (mss_pkg::FRAC_BITS - 1)));
    ci = q_clamp(((longint'(py) * 2) << mss_pkg::FRAC_BITS) / longint'(mss_pkg::IMAGE_HEIGHT)
                 - (longint'(1) << mss_pkg::FRAC_BITS));
    zr = cr;
    zi = ci;
    n  = 0;
    mag2 = q_clamp(q_mul(zr, zr) + q_mul(zi, zi));
    while (mag2 < Q_ESCAPE && n < lim) begin
      rr = q_mul(zr, zr);
      ii = q_mul(zi, zi);
      ri = q_mul(zr, zi);
      n++;
      zr   = q_clamp(q_clamp(rr - ii) + cr);
      zi   = q_clamp(q_clamp(ri + ri) + ci);
      mag2 = q_clamp(q_mul(zr, zr) + q_mul(zi, zi));
    end
    r.iters = mss_pkg::LIMIT_W'(n);
    if (mag2 < Q_ESCAPE) begin
      r.shade  = mss_pkg::SHADE_MAX;
      r.in_set = 1'b1;
      return r;
    end
    // mu = n + 1 - log2(ln|z|), shade = 128*log2(mu/32 + 1)
    lg = log2_q16(mag2, mss_pkg::FRAC_BITS);
    ll = log2_q16(lg, 16) + LOG2_LN2_M1;
    mu = (longint'(n + 1) << 16) - ll;
    if (mu < 0) mu = 0;
    lv = log2_q16((mu >>> 5) + 65536, 16);
    if (lv < 0) lv = 0;
    lv = lv >>> 9;
    r.shade  = (lv > longint'(mss_pkg::SHADE_MAX)) ? mss_pkg::SHADE_MAX
                                                   : mss_pkg::SHADE_W'(lv);
    r.in_set = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  = mss_pkg::LIMIT_RESET;
      errors_o = 0;
      shades_due.delete();
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (pix.valid && pix.ready) begin
        shades_due.push_back(predict_shade(pix.pixel_x, pix.pixel_y, limit_q));
      end
      if (res.valid && res.ready) begin
        if (shades_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("unexpected result: shade %0d iter %0d in_set %0b",
                     res.shade, res.iterations_used, res.inside_set);
          end
        end else begin
          want = shades_due.pop_front();
          if (res.shade !== want.shade || res.iterations_used !== want.iters ||
              res.inside_set !== want.in_set) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("mismatch x=%0d y=%0d: expected shade %0d iter %0d in_set %0b, %s",
                       want.px, want.py, want.shade, want.iters, want.in_set,
                       $sformatf("got shade %0d iter %0d in_set %0b",
                                 res.shade, res.iterations_used, res.inside_set));
            end
          end
        end
      end
    end
    outstanding_o = shades_due.size();
  end

endmodule

>>> sim/tb_mandelbrot_smooth_shade.sv
`timescale 1ns / 1ps

module tb_mandelbrot_smooth_shade;

  // Guard: watchdog bound on the whole run
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Settle time after the last result before the verdict
  localparam int unsigned TAIL_CYCLES = 40;
  // Long output hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PIX_MAX     = (1 << mss_pkg::PIX_W) - 1;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [mss_pkg::LIMIT_W-1:0] cfg_wdata = '0;

  // Idle knobs, percent of cycles
  int unsigned send_gap_pct   = 0;
  int unsigned sink_stall_pct = 0;
  // Hold-off handshake between stimulus and receiver
  int unsigned hold_requests  = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned errors;
  int unsigned outstanding;

  mss_pix_if   pix ();
  mss_shade_if res ();

  mandelbrot_smooth_shade DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix),
    .shade_o     (res)
  );

  mss_shade_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .pix           (pix),
    .res           (res),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one pixel request; returns at the edge it is taken. valid stays
  // high so a back-to-back request needs no extra assignment.
  task automatic send_pixel(input logic [mss_pkg::PIX_W-1:0] x,
                            input logic [mss_pkg::PIX_W-1:0] y);
    while ($urandom_range(99) < send_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= x;
    pix.pixel_y <= y;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(mss_pkg::PIX_W'($urandom_range(PIX_MAX)),
                              mss_pkg::PIX_W'($urandom_range(PIX_MAX)));
  endtask

  // Drain the block, then write the iteration limit
  task automatic program_limit(input logic [mss_pkg::LIMIT_W-1:0] value);
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    pix.valid   <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset limit of 128, no idling.
    // Corners escape fast.
    send_pixel('0, '0);
    send_pixel(mss_pkg::PIX_W'(PIX_MAX), mss_pkg::PIX_W'(PIX_MAX));
    send_pixel('0, mss_pkg::PIX_W'(PIX_MAX));
    send_pixel(mss_pkg::PIX_W'(PIX_MAX), '0);
    // c = 0, -0.5, -1, ~-1.5: never escape
    send_pixel(mss_pkg::PIX_W'(768), mss_pkg::PIX_W'(512));
    send_pixel(mss_pkg::PIX_W'(512), mss_pkg::PIX_W'(512));
    send_pixel(mss_pkg::PIX_W'(256), mss_pkg::PIX_W'(512));
    send_pixel(mss_pkg::PIX_W'(1), mss_pkg::PIX_W'(512));
    // c = 0.25: cusp, crawls but stays bounded
    send_pixel(mss_pkg::PIX_W'(896), mss_pkg::PIX_W'(512));
    send_pixel(mss_pkg::PIX_W'(PIX_MAX), mss_pkg::PIX_W'(512));
    send_pixel(mss_pkg::PIX_W'(512), '0);
    send_pixel(mss_pkg::PIX_W'(640), mss_pkg::PIX_W'(800));

    // Limit of zero: only c itself is tested, nothing escapes
    program_limit('0);
    send_pixel(mss_pkg::PIX_W'(768), mss_pkg::PIX_W'(512));
    send_pixel('0, '0);
    send_pixel(mss_pkg::PIX_W'(PIX_MAX), mss_pkg::PIX_W'(PIX_MAX));
    send_pixel(mss_pkg::PIX_W'(300), mss_pkg::PIX_W'(700));

    // Largest limit: slow escapes near the boundary push the shade into the clamp
    program_limit({mss_pkg::LIMIT_W{1'b1}});
    send_pixel(mss_pkg::PIX_W'(384), mss_pkg::PIX_W'(517));
    send_pixel(mss_pkg::PIX_W'(897), mss_pkg::PIX_W'(512));
    send_pixel(mss_pkg::PIX_W'(896), mss_pkg::PIX_W'(513));
    send_random(5);

    // Limit of one, sender gaps; result side held off at the start so the
    // block fills and stalls its input
    program_limit(mss_pkg::LIMIT_W'(1));
    send_gap_pct  = 64;
    hold_requests = hold_requests + 1;
    send_random(30);

    // Reset value written back, no idling
    program_limit(mss_pkg::LIMIT_RESET);
    send_gap_pct = 0;
    send_random(250);

    program_limit(mss_pkg::LIMIT_W'(37));
    send_gap_pct = 64;
    send_random(200);

    // Receiver stalls
    program_limit(mss_pkg::LIMIT_W'(300));
    send_gap_pct   = 0;
    sink_stall_pct = 64;
    send_random(150);

    // Both sides idle
    program_limit(mss_pkg::LIMIT_W'(64));
    send_gap_pct   = 27;
    sink_stall_pct = 27;
    send_random(200);

    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
